// ===== sv/assert_macros.svh =====
// Shared assertion macros for the decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge while reset is low.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/utf8d_pkg.sv =====
package utf8d_pkg;

   localparam int unsigned CpWidth   = 21;
   localparam int unsigned ByteWidth = 8;
   localparam int unsigned RemWidth  = 2;
   localparam int unsigned LenWidth  = 3;

   localparam logic [CpWidth-1:0] MinCodePointReset = 21'd32;
   localparam logic [5:0] ContMask = 6'h3F;

   // Sequence lengths of a leading byte.
   localparam logic [LenWidth-1:0] LEN_NONE  = 3'd0;
   localparam logic [LenWidth-1:0] LEN_ONE   = 3'd1;
   localparam logic [LenWidth-1:0] LEN_TWO   = 3'd2;
   localparam logic [LenWidth-1:0] LEN_THREE = 3'd3;
   localparam logic [LenWidth-1:0] LEN_FOUR  = 3'd4;

   typedef logic [LenWidth-1:0] seq_len_type;

   typedef struct packed {
      logic               emit;
      logic [CpWidth-1:0] code_point;
      logic               incomplete_error;
   } result_type;

   // Length from the top five bits of a leading byte.
   function automatic seq_len_type lead_length(input logic [ByteWidth-1:0] b);
      seq_len_type len;
      unique case (b[7:3]) inside
         [5'd0:5'd15]:  len = LEN_ONE;
         [5'd16:5'd23]: len = LEN_NONE;
         [5'd24:5'd27]: len = LEN_TWO;
         [5'd28:5'd29]: len = LEN_THREE;
         5'd30:         len = LEN_FOUR;
         default:       len = LEN_NONE;
      endcase
      return len;
   endfunction

   // Payload bits of a leading byte, by sequence length.
   function automatic logic [ByteWidth-1:0] lead_mask(input seq_len_type len);
      logic [ByteWidth-1:0] m;
      unique case (len)
         LEN_ONE:   m = 8'h7F;
         LEN_TWO:   m = 8'h1F;
         LEN_THREE: m = 8'h0F;
         LEN_FOUR:  m = 8'h07;
         default:   m = 8'h00;
      endcase
      return m;
   endfunction

endpackage

// ===== sv/utf8d_decode.sv =====
module utf8d_decode (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [7:0]                    data_byte,
   input  logic                          end_of_input,
   input  logic [utf8d_pkg::CpWidth-1:0] min_code_point,
   output utf8d_pkg::result_type         result
);
   import utf8d_pkg::*;
   `include "assert_macros.svh"

   logic [RemWidth-1:0] remaining_ff, remaining_in;
   logic [CpWidth-1:0]  partial_ff, partial_in;

   seq_len_type         len;
   logic [ByteWidth-1:0] lead_bits;
   logic [CpWidth-1:0]  shifted;
   logic [CpWidth-1:0]  cp;
   logic                done;

   always_comb begin
      len       = lead_length(data_byte);
      lead_bits = data_byte & lead_mask(len);
      shifted   = {partial_ff[CpWidth-7:0], data_byte[5:0] & ContMask};

      remaining_in = remaining_ff;
      partial_in   = partial_ff;
      cp           = '0;
      done         = 1'b0;

      if (remaining_ff == '0) begin
         if (len <= LEN_ONE) begin
            cp   = {{(CpWidth-ByteWidth){1'b0}}, lead_bits};
            done = 1'b1;
         end else begin
            partial_in   = {{(CpWidth-ByteWidth){1'b0}}, lead_bits};
            remaining_in = RemWidth'(len - LEN_ONE);
         end
      end else begin
         remaining_in = remaining_ff - 1'b1;
         partial_in   = shifted;
         if (remaining_ff == 2'd1) begin
            cp         = shifted;
            partial_in = '0;
            done       = 1'b1;
         end
      end

      result.emit             = done && (cp >= min_code_point);
      result.code_point       = cp;
      result.incomplete_error = 1'b0;

      // The stream ended while the sequence still wants bytes.
      if (!done && end_of_input) begin
         remaining_in            = '0;
         partial_in              = '0;
         result.emit             = 1'b1;
         result.code_point       = '0;
         result.incomplete_error = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remaining_ff <= '0;
         partial_ff   <= '0;
      end else if (accept) begin
         remaining_ff <= remaining_in;
         partial_ff   <= partial_in;
      end
   end

   `ASSERT_CLK(a_idle_partial_clear, clock, reset,
      (remaining_ff == 2'd0) |-> (partial_ff == '0), "partial value left over between sequences")
   `ASSERT_CLK(a_partial_width, clock, reset,
      ((remaining_ff == 2'd3) |-> (partial_ff[CpWidth-1:3] == '0)) and
      ((remaining_ff == 2'd2) |-> (partial_ff[CpWidth-1:9] == '0)) and
      ((remaining_ff == 2'd1) |-> (partial_ff[CpWidth-1:15] == '0)),
      "partial value wider than the bytes gathered so far")

endmodule

// ===== sv/utf8d_out_reg.sv =====
module utf8d_out_reg (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  utf8d_pkg::result_type         result,
   output logic                          can_load,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [utf8d_pkg::CpWidth-1:0] rsp_code_point,
   output logic                          rsp_incomplete_error
);
   import utf8d_pkg::*;
   `include "assert_macros.svh"

   logic               valid_ff, valid_in;
   logic [CpWidth-1:0] cp_ff;
   logic               err_ff;

   // A waiting beat leaves at the same edge that a new one arrives.
   assign can_load = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = result.emit;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && result.emit) begin
         cp_ff  <= result.code_point;
         err_ff <= result.incomplete_error;
      end
   end

   assign rsp_valid            = valid_ff;
   assign rsp_code_point       = cp_ff;
   assign rsp_incomplete_error = err_ff;

   `ASSERT_CLK(a_error_zero_cp, clock, reset,
      (valid_ff && err_ff) |-> (cp_ff == '0), "error beat carries a nonzero code point")
   `ASSERT_CLK(a_load_shows, clock, reset,
      (load && result.emit) |=> valid_ff, "emitted result did not reach the output")

endmodule

// ===== sv/utf8_code_point_decoder_core.sv =====
// Channel | Direction | Handshake           | Payload
// req     | in        | req_valid/req_ready | req_data_byte, req_end_of_input
// rsp     | out       | rsp_valid/rsp_ready | rsp_code_point, rsp_incomplete_error
// csr     | in        | csr_write_enable    | csr_write_data (min_code_point)
//
// One byte per cycle unless stalled; its result, if any, shows in the next cycle.
// Decoding runs in one pass from the sequence state registers into the output register.
// A held result stalls input only while rsp_ready is low.
// Reset clears the sequence state, drops any held beat and sets min_code_point to 32.
module utf8_code_point_decoder_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [7:0]                    req_data_byte,
   input  logic                          req_end_of_input,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [utf8d_pkg::CpWidth-1:0] rsp_code_point,
   output logic                          rsp_incomplete_error,
   input  logic                          csr_write_enable,
   input  logic [utf8d_pkg::CpWidth-1:0] csr_write_data
);
   import utf8d_pkg::*;

   logic [CpWidth-1:0] min_cp_ff;
   logic               accept;
   logic               can_load;
   result_type         result;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_cp_ff <= MinCodePointReset;
      end else if (csr_write_enable) begin
         min_cp_ff <= csr_write_data;
      end
   end

   assign req_ready = can_load;
   assign accept    = req_valid && can_load;

   utf8d_decode u_decode (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .data_byte      (req_data_byte),
      .end_of_input   (req_end_of_input),
      .min_code_point (min_cp_ff),
      .result         (result)
   );

   utf8d_out_reg u_out_reg (
      .clock                (clock),
      .reset                (reset),
      .load                 (accept),
      .result               (result),
      .can_load             (can_load),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_code_point       (rsp_code_point),
      .rsp_incomplete_error (rsp_incomplete_error)
   );

endmodule
